@@ design/tbdsa_pkg.sv @@
// Shared types and constants for the texture block deswizzle address generator.
// Used by tbdsa_swz and texture_block_deswizzle_address_top; depends on nothing.
`default_nettype none

package tbdsa_pkg;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BPB_LOG2 = 2'd0,
    CFG_WIDTH    = 2'd1,
    CFG_HEIGHT   = 2'd2
  } cfg_idx_e;

  // Fixed field widths.
  localparam int unsigned SliceW   = 8;
  localparam int unsigned CoordW   = 12;
  localparam int unsigned BplW     = 3;
  localparam int unsigned AddrW    = 36;
  localparam int unsigned MaxBplog = 4;
  // Column index in bytes: coordinate shifted by up to the largest block size.
  localparam int unsigned XbW      = CoordW + MaxBplog;
  // Shift applied to the column tail ranges over 3..7.
  localparam int unsigned ColShW   = 3;
  localparam int unsigned ColShMin = 3;

  typedef struct packed {
    logic [SliceW-1:0] slice_index;
    logic [CoordW-1:0] block_x;
    logic [CoordW-1:0] block_y;
  } item_t;

  typedef struct packed {
    logic [AddrW-1:0] src_addr;
    logic [AddrW-1:0] dst_addr;
    logic             in_range;
  } result_t;

endpackage

`default_nettype wire

@@ design/texture_block_deswizzle_address_top.sv @@
// Top level of the texture block deswizzle address generator.
// Depends on tbdsa_pkg and instantiates tbdsa_swz.
//
// Usage: software sets bytes per block (as log2), width and height in blocks
// through the write port (cfg_we_i, cfg_idx_i, cfg_data_i) while no beat is in
// flight. Each beat on item_i is taken at a clock edge with start_i high; busy_o
// is always low, so a new block coordinate may enter every cycle.
// For every beat the block returns one result on result_o, marked by done_o for
// a single cycle, once the beat has passed three registered stages: one stage forms
// the swizzled in-slice offset and the surface products, one forms the slice
// offsets and the range check, and one adds them into the output register.
// Throughput is one block per cycle; the three stages set only the latency.
// The receiver has no way to hold results off, and results come out in order.
// Reset clears all valid bits and restores the registers to 4 bytes per block,
// a 1 by 1 surface; no beat is in flight after reset.
// Results: src_addr is the swizzled source offset, dst_addr the linear one, and
// in_range is low for blocks outside the surface or past the aligned surface.
`default_nettype none

module texture_block_deswizzle_address_top #(
  parameter int unsigned MAX_DIM_LOG2 = 12,
  parameter int unsigned SLICE_BITS   = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire tbdsa_pkg::item_t                   item_i,
  output logic                                    done_o,
  output tbdsa_pkg::result_t                      result_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [tbdsa_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [tbdsa_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned DW   = MAX_DIM_LOG2 + 1;
  localparam int unsigned CMPW = (DW > tbdsa_pkg::CfgDataW) ? DW : tbdsa_pkg::CfgDataW;
  localparam int unsigned LSW  = $clog2(MAX_DIM_LOG2 + 5);
  localparam int unsigned HLW  = $clog2(MAX_DIM_LOG2 + 1);
  localparam int unsigned SB   = (SLICE_BITS < tbdsa_pkg::SliceW) ? SLICE_BITS
                                                                  : tbdsa_pkg::SliceW;
  localparam int unsigned SW   = 2 * DW + 3;
  localparam int unsigned LAW  = (16 + MAX_DIM_LOG2 > 23) ? 16 + MAX_DIM_LOG2 : 23;
  localparam int unsigned CW   = ((LAW > SW) ? LAW : SW) + 1;
  localparam int unsigned LW   = 16 + DW;
  localparam int unsigned PW   = SB + SW;
  localparam logic [DW-1:0] Top = {1'b1, {MAX_DIM_LOG2{1'b0}}};

  // Configuration registers.
  logic [tbdsa_pkg::BplW-1:0]     bpl_q;
  logic [tbdsa_pkg::CfgDataW-1:0] width_q;
  logic [tbdsa_pkg::CfgDataW-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpl_q    <= tbdsa_pkg::BplW'(2);
      width_q  <= tbdsa_pkg::CfgDataW'(1);
      height_q <= tbdsa_pkg::CfgDataW'(1);
    end else if (cfg_we_i) begin
      unique case (tbdsa_pkg::cfg_idx_e'(cfg_idx_i))
        tbdsa_pkg::CFG_BPB_LOG2: bpl_q    <= cfg_data_i[tbdsa_pkg::BplW-1:0];
        tbdsa_pkg::CFG_WIDTH:    width_q  <= cfg_data_i;
        tbdsa_pkg::CFG_HEIGHT:   height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Surface geometry from the registers.
  logic [DW-1:0]                  w_clamp;
  logic [DW-1:0]                  h_clamp;
  logic [DW-1:0]                  h_less;
  logic [tbdsa_pkg::BplW-1:0]     bl;
  logic [HLW-1:0]                 w_top;
  logic [HLW-1:0]                 h_less_top;
  logic [HLW-1:0]                 hl;
  logic [LSW-1:0]                 line_shift;
  logic [tbdsa_pkg::ColShW-1:0]   col_shift;

  always_comb begin
    bl = (bpl_q > tbdsa_pkg::BplW'(tbdsa_pkg::MaxBplog)) ?
         tbdsa_pkg::BplW'(tbdsa_pkg::MaxBplog) : bpl_q;

    if (width_q == '0) begin
      w_clamp = DW'(1);
    end else if (CMPW'(width_q) > CMPW'(Top)) begin
      w_clamp = Top;
    end else begin
      w_clamp = DW'(width_q);
    end

    if (height_q == '0) begin
      h_clamp = DW'(1);
    end else if (CMPW'(height_q) > CMPW'(Top)) begin
      h_clamp = Top;
    end else begin
      h_clamp = DW'(height_q);
    end

    h_less = h_clamp - DW'(1);

    w_top      = '0;
    h_less_top = '0;
    for (int i = 0; i < DW; i++) begin
      if (w_clamp[i]) w_top = HLW'(i);
      if (h_less[i])  h_less_top = HLW'(i);
    end

    // Height rounded up to a power of two is 2^hl.
    hl = (h_less == '0) ? '0 : h_less_top + HLW'(1);

    line_shift = LSW'(w_top) + LSW'(bl);

    // One extra column bit for each of mask bits 3 to 6 that is set.
    if (LSW'(hl) <= LSW'(3)) begin
      col_shift = tbdsa_pkg::ColShW'(tbdsa_pkg::ColShMin);
    end else if (LSW'(hl) >= LSW'(7)) begin
      col_shift = tbdsa_pkg::ColShW'(tbdsa_pkg::ColShMin + 4);
    end else begin
      col_shift = tbdsa_pkg::ColShW'(hl);
    end
  end

  // Stage A: swizzled offset and the two dimension products.
  logic [tbdsa_pkg::XbW-1:0] xb;
  logic [LAW-1:0]            swz_addr;

  assign xb = tbdsa_pkg::XbW'(item_i.block_x) << bl;

  tbdsa_swz #(
    .LAW (LAW),
    .LSW (LSW)
  ) u_swz (
    .by_i         (item_i.block_y),
    .xb_i         (xb),
    .line_shift_i (line_shift),
    .col_shift_i  (col_shift),
    .addr_o       (swz_addr)
  );

  logic                              valid_a_q;
  logic [SB-1:0]                     slice_a_q;
  logic [tbdsa_pkg::CoordW-1:0]      bx_a_q;
  logic [tbdsa_pkg::BplW-1:0]        bl_a_q;
  logic [DW-1:0]                     w_a_q;
  logic [HLW-1:0]                    hl_a_q;
  logic [LAW-1:0]                    addr_a_q;
  logic [2*DW-1:0]                   wh_a_q;
  logic [tbdsa_pkg::CoordW+DW-1:0]   ybw_a_q;
  logic                              xy_ok_a_q;

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slice_a_q <= item_i.slice_index[SB-1:0];
      bx_a_q    <= item_i.block_x;
      bl_a_q    <= bl;
      w_a_q     <= w_clamp;
      hl_a_q    <= hl;
      addr_a_q  <= swz_addr;
      wh_a_q    <= (2*DW)'(w_clamp) * (2*DW)'(h_clamp);
      ybw_a_q   <= (tbdsa_pkg::CoordW+DW)'(item_i.block_y) * (tbdsa_pkg::CoordW+DW)'(w_clamp);
      xy_ok_a_q <= (CMPW'(item_i.block_x) < CMPW'(w_clamp)) &&
                   (CMPW'(item_i.block_y) < CMPW'(h_clamp));
    end
  end

  // Stage B: surface sizes, slice offsets, linear offset and range check.
  logic [SW-1:0]  aligned_b;
  logic [SW-1:0]  plain_b;
  logic [LSW-1:0] align_sh_b;
  logic [CW-1:0]  bpb_b;
  logic [PW-1:0]  sa_prod;
  logic [PW-1:0]  sp_prod;
  logic [LW-1:0]  lin_b;
  logic           ok_b;

  always_comb begin
    align_sh_b = LSW'(hl_a_q) + LSW'(bl_a_q);
    aligned_b  = SW'(w_a_q) << align_sh_b;
    plain_b    = SW'(wh_a_q) << bl_a_q;
    bpb_b      = CW'(1) << bl_a_q;
    sa_prod    = PW'(slice_a_q) * PW'(aligned_b);
    sp_prod    = PW'(slice_a_q) * PW'(plain_b);
    lin_b      = (LW'(ybw_a_q) + LW'(bx_a_q)) << bl_a_q;
    ok_b       = xy_ok_a_q && ((CW'(addr_a_q) + bpb_b) <= CW'(aligned_b));
  end

  logic                        valid_b_q;
  logic [tbdsa_pkg::AddrW-1:0] sa_b_q;
  logic [tbdsa_pkg::AddrW-1:0] sp_b_q;
  logic [LAW-1:0]              addr_b_q;
  logic [LW-1:0]               lin_b_q;
  logic                        ok_b_q;

  always_ff @(posedge clk_i) begin
    if (valid_a_q) begin
      sa_b_q   <= tbdsa_pkg::AddrW'(sa_prod);
      sp_b_q   <= tbdsa_pkg::AddrW'(sp_prod);
      addr_b_q <= addr_a_q;
      lin_b_q  <= lin_b;
      ok_b_q   <= ok_b;
    end
  end

  // Stage C: final adds into the output register.
  logic               valid_c_q;
  tbdsa_pkg::result_t result_q;

  always_ff @(posedge clk_i) begin
    if (valid_b_q) begin
      result_q.src_addr <= sa_b_q + tbdsa_pkg::AddrW'(addr_b_q);
      result_q.dst_addr <= sp_b_q + tbdsa_pkg::AddrW'(lin_b_q);
      result_q.in_range <= ok_b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else begin
      valid_a_q <= accept;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  assign done_o   = valid_c_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

@@ design/tbdsa_swz.sv @@
// Block-linear swizzle of one block coordinate into a byte offset within a slice.
// Depends on tbdsa_pkg for field widths.
`default_nettype none

module tbdsa_swz #(
  parameter int unsigned LAW = 28,
  parameter int unsigned LSW = 5
) (
  input  wire logic [tbdsa_pkg::CoordW-1:0] by_i,
  input  wire logic [tbdsa_pkg::XbW-1:0]    xb_i,
  input  wire logic [LSW-1:0]               line_shift_i,
  input  wire logic [tbdsa_pkg::ColShW-1:0] col_shift_i,
  output logic      [LAW-1:0]               addr_o
);

  logic [LAW-1:0] row_tail;
  logic [LAW-1:0] row_low;
  logic [LAW-1:0] col_tail;
  logic [LAW-1:0] col_low;

  always_comb begin
    // Rows above bit 6 step by whole row pitches; row bits 0 to 2 interleave with
    // the low byte-column bits inside a 512-byte group of blocks, and bits 3 to 6 sit above it.
    row_tail = LAW'({by_i[tbdsa_pkg::CoordW-1:7], 7'b0}) << line_shift_i;
    row_low  = LAW'({by_i[6:3], 9'b0}) | LAW'({by_i[2:1], 6'b0}) | LAW'({by_i[0], 4'b0});
    col_tail = LAW'({xb_i[tbdsa_pkg::XbW-1:6], 6'b0}) << col_shift_i;
    col_low  = LAW'({xb_i[5], 8'b0}) | LAW'({xb_i[4], 5'b0}) | LAW'(xb_i[3:0]);
    addr_o   = row_tail | row_low | col_tail | col_low;
  end

endmodule

`default_nettype wire
